// ===== hw/rtl/tsq_pkg.sv =====
package tsq_pkg;

    // Letter alphabet: five-bit codes, one position entry per code
    localparam int LETTER_W = 5;
    localparam int LETTERS  = 1 << LETTER_W;
    localparam int PICK_W   = 3;
    localparam int SEL_W    = 2;
    localparam int CELL_W   = 5;
    localparam int SIDE_DEF = 5;

    // Most letters one item produces
    localparam int MAX_OUT  = 3;
    localparam int CNT_W    = 2;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_ENCRYPT = 2'd1,
        MODE_DECRYPT = 2'd2,
        MODE_PASS    = 2'd3
    } mode_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_FIRST  = 2'd0,
        SEL_SECOND = 2'd1,
        SEL_THIRD  = 2'd2,
        SEL_NONE   = 2'd3
    } sel_t;

    typedef struct packed {
        mode_t               mode;
        logic [SEL_W-1:0]    square_sel;
        logic [CELL_W-1:0]   cell_req;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
        logic [LETTER_W-1:0] letter_c;
        logic [PICK_W-1:0]   pick_row;
        logic [PICK_W-1:0]   pick_col;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_out;
        logic                last;
    } result_t;

    // Second pipeline stage as seen by the output serialiser
    typedef struct packed {
        logic                valid;
        mode_t               mode;
        logic [LETTER_W-1:0] letter;
    } stage_t;

endpackage

// ===== hw/rtl/tsq_ram.sv =====
module tsq_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read old contents on a same-cycle write; hold read data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/tsq_addr.sv =====
module tsq_addr #(
    parameter int SIDE = tsq_pkg::SIDE_DEF
) (
    input  tsq_pkg::mode_t                        mode,
    input  logic [tsq_pkg::PICK_W-1:0]            pick_row,
    input  logic [tsq_pkg::PICK_W-1:0]            pick_col,
    input  logic [$clog2(SIDE*SIDE)-1:0]          pos1,
    input  logic [$clog2(SIDE*SIDE)-1:0]          pos2,
    input  logic [$clog2(SIDE*SIDE)-1:0]          pos3,
    output logic [$clog2(SIDE*SIDE)-1:0]          addr1,
    output logic [$clog2(SIDE*SIDE)-1:0]          addr2,
    output logic [$clog2(SIDE*SIDE)-1:0]          addr3
);

    localparam int NCELL   = SIDE * SIDE;
    localparam int CELL_AW = $clog2(NCELL);
    localparam int ROW_W   = $clog2(SIDE);

    // Row of a cell index by parallel compares against row starts
    function automatic logic [ROW_W-1:0] row_of(input logic [CELL_AW-1:0] pos);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 1; k < SIDE; k++)
        begin
            if (int'(pos) >= k * SIDE)
            begin
                r = ROW_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] col_of(input logic [CELL_AW-1:0] pos);
        return ROW_W'(int'(pos) - int'(row_of(pos)) * SIDE);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_at(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
        return CELL_AW'(int'(r) * SIDE + int'(c));
    endfunction

    function automatic logic [ROW_W-1:0] clamp(input logic [tsq_pkg::PICK_W-1:0] p);
        return (int'(p) >= SIDE) ? ROW_W'(SIDE - 1) : ROW_W'(p);
    endfunction

    // pos1: first square position of letter a
    // pos2: second square position (letter b on encrypt, letter c on decrypt)
    // pos3: third square position of letter b
    always_comb
    begin
        case (mode)
            tsq_pkg::MODE_DECRYPT:
            begin
                addr1 = cell_at(row_of(pos3), col_of(pos1));
                addr2 = cell_at(row_of(pos2), col_of(pos3));
                addr3 = '0;
            end
            default:
            begin
                addr1 = cell_at(clamp(pick_row), col_of(pos1));
                addr3 = cell_at(row_of(pos1), col_of(pos2));
                addr2 = cell_at(row_of(pos2), clamp(pick_col));
            end
        endcase
    end

endmodule

// ===== hw/rtl/tsq_out.sv =====
module tsq_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsq_pkg::stage_t                 stage,
    input  logic [tsq_pkg::LETTER_W-1:0]    sq1_data,
    input  logic [tsq_pkg::LETTER_W-1:0]    sq2_data,
    input  logic [tsq_pkg::LETTER_W-1:0]    sq3_data,
    output logic                            take,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tsq_pkg::result_t                result
);

    logic [tsq_pkg::LETTER_W-1:0] letter_reg [tsq_pkg::MAX_OUT];
    logic [tsq_pkg::LETTER_W-1:0] letter_next [tsq_pkg::MAX_OUT];
    logic [tsq_pkg::CNT_W-1:0]    left_reg;
    logic [tsq_pkg::CNT_W-1:0]    left_next;
    logic                         beat;

    assign beat         = result_valid && result_ready;
    assign result_valid = (left_reg != '0);
    assign result.letter_out = letter_reg[0];
    assign result.last       = (left_reg == tsq_pkg::CNT_W'(1));

    // Reload once the buffer is empty or its final beat leaves
    assign take = stage.valid && (!result_valid || (beat && result.last));

    always_comb
    begin
        left_next   = left_reg;
        letter_next = letter_reg;
        if (take)
        begin
            case (stage.mode)
                tsq_pkg::MODE_ENCRYPT:
                begin
                    letter_next[0] = sq1_data;
                    letter_next[1] = sq3_data;
                    letter_next[2] = sq2_data;
                    left_next      = tsq_pkg::CNT_W'(3);
                end
                tsq_pkg::MODE_DECRYPT:
                begin
                    letter_next[0] = sq1_data;
                    letter_next[1] = sq2_data;
                    letter_next[2] = sq2_data;
                    left_next      = tsq_pkg::CNT_W'(2);
                end
                default:
                begin
                    letter_next[0] = stage.letter;
                    letter_next[1] = stage.letter;
                    letter_next[2] = stage.letter;
                    left_next      = tsq_pkg::CNT_W'(1);
                end
            endcase
        end
        else if (beat)
        begin
            // Advance to the next letter of the item
            letter_next[0] = letter_reg[1];
            letter_next[1] = letter_reg[2];
            left_next      = left_reg - tsq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
    end

endmodule

// ===== hw/rtl/trisquare_cipher_engine.sv =====
// Tri-square cipher engine.
// Item channel (item_valid/item_ready/item): one beat per command. Load beats
// write one cell of a square and its letter-to-cell entry; they give no
// result. Encrypt beats give three letters, decrypt beats two, pass beats one.
// Result channel (result_valid/result_ready/result): one letter per beat, with
// last set on the final letter of each item.
// The first letter of an item passes the position lookup on the edge that
// takes its beat, then the square lookup, then the output buffer, and is
// offered from the output buffer.
// Throughput: one letter per cycle on the result channel while the receiver
// is ready, so pass items flow one per cycle; encrypt and decrypt items take
// one letter beat per letter. The single-letter result channel sets the rate;
// the lookup pipeline accepts a new item every cycle unless stalled behind it.
// A square entry must be loaded before any item reads it.
// Reset clears the pipeline and the output buffer; square contents are kept
// as undefined until loaded.
// When the receiver stalls, the current letter holds, the two lookup stages
// fill, and item_ready then drops until the output buffer drains.
module trisquare_cipher_engine #(
    parameter int SIDE = tsq_pkg::SIDE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tsq_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output tsq_pkg::result_t  result
);

    localparam int NCELL   = SIDE * SIDE;
    localparam int CELL_AW = $clog2(NCELL);
    localparam int LET_AW  = $clog2(tsq_pkg::LETTERS);

    logic                          accept;
    logic                          is_load;
    logic                          cell_ok;
    logic [CELL_AW-1:0]            cell_idx;
    logic [LET_AW-1:0]             pos2_raddr;
    logic                          we1;
    logic                          we2;
    logic                          we3;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    tsq_pkg::mode_t                s1_mode_reg;
    logic [tsq_pkg::PICK_W-1:0]    s1_row_reg;
    logic [tsq_pkg::PICK_W-1:0]    s1_col_reg;
    logic [tsq_pkg::LETTER_W-1:0]  s1_letter_reg;
    logic                          s1_adv;

    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    tsq_pkg::mode_t                s2_mode_reg;
    logic [tsq_pkg::LETTER_W-1:0]  s2_letter_reg;
    logic                          s2_take;
    logic                          s2_free;
    tsq_pkg::stage_t               s2_stage;

    logic [CELL_AW-1:0]            pos1;
    logic [CELL_AW-1:0]            pos2;
    logic [CELL_AW-1:0]            pos3;
    logic [CELL_AW-1:0]            addr1;
    logic [CELL_AW-1:0]            addr2;
    logic [CELL_AW-1:0]            addr3;
    logic [tsq_pkg::LETTER_W-1:0]  sq1_data;
    logic [tsq_pkg::LETTER_W-1:0]  sq2_data;
    logic [tsq_pkg::LETTER_W-1:0]  sq3_data;

    // Handshake and flow control between stages
    assign s2_free    = !s2_valid_reg || s2_take;
    assign s1_adv     = s1_valid_reg && s2_free;
    assign item_ready = !s1_valid_reg || s1_adv;
    assign accept     = item_valid && item_ready;
    assign is_load    = (item.mode == tsq_pkg::MODE_LOAD);

    // Load decode: drop bad cells and the unused square select
    assign cell_ok  = (32'(item.cell_req) < NCELL);
    assign cell_idx = CELL_AW'(item.cell_req);
    assign we1 = accept && is_load && cell_ok && (item.square_sel == tsq_pkg::SEL_FIRST);
    assign we2 = accept && is_load && cell_ok && (item.square_sel == tsq_pkg::SEL_SECOND);
    assign we3 = accept && is_load && cell_ok && (item.square_sel == tsq_pkg::SEL_THIRD);

    assign pos2_raddr = (item.mode == tsq_pkg::MODE_DECRYPT) ? item.letter_c : item.letter_b;

    // Letter-to-cell maps, looked up as the beat is taken
    tsq_ram #(.WIDTH(CELL_AW), .DEPTH(tsq_pkg::LETTERS)) u_pos1 (
        .clk   (clk),
        .we    (we1),
        .waddr (item.letter_a),
        .wdata (cell_idx),
        .re    (accept),
        .raddr (item.letter_a),
        .rdata (pos1)
    );

    tsq_ram #(.WIDTH(CELL_AW), .DEPTH(tsq_pkg::LETTERS)) u_pos2 (
        .clk   (clk),
        .we    (we2),
        .waddr (item.letter_a),
        .wdata (cell_idx),
        .re    (accept),
        .raddr (pos2_raddr),
        .rdata (pos2)
    );

    tsq_ram #(.WIDTH(CELL_AW), .DEPTH(tsq_pkg::LETTERS)) u_pos3 (
        .clk   (clk),
        .we    (we3),
        .waddr (item.letter_a),
        .wdata (cell_idx),
        .re    (accept),
        .raddr (item.letter_b),
        .rdata (pos3)
    );

    // Cell addresses from row and column of the looked-up positions
    tsq_addr #(.SIDE(SIDE)) u_addr (
        .mode     (s1_mode_reg),
        .pick_row (s1_row_reg),
        .pick_col (s1_col_reg),
        .pos1     (pos1),
        .pos2     (pos2),
        .pos3     (pos3),
        .addr1    (addr1),
        .addr2    (addr2),
        .addr3    (addr3)
    );

    // Letter squares, read as stage one advances
    tsq_ram #(.WIDTH(tsq_pkg::LETTER_W), .DEPTH(NCELL)) u_sq1 (
        .clk   (clk),
        .we    (we1),
        .waddr (cell_idx),
        .wdata (item.letter_a),
        .re    (s1_adv),
        .raddr (addr1),
        .rdata (sq1_data)
    );

    tsq_ram #(.WIDTH(tsq_pkg::LETTER_W), .DEPTH(NCELL)) u_sq2 (
        .clk   (clk),
        .we    (we2),
        .waddr (cell_idx),
        .wdata (item.letter_a),
        .re    (s1_adv),
        .raddr (addr2),
        .rdata (sq2_data)
    );

    tsq_ram #(.WIDTH(tsq_pkg::LETTER_W), .DEPTH(NCELL)) u_sq3 (
        .clk   (clk),
        .we    (we3),
        .waddr (cell_idx),
        .wdata (item.letter_a),
        .re    (s1_adv),
        .raddr (addr3),
        .rdata (sq3_data)
    );

    // Stage valid bits: loads finish at the input and never enter
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_adv;
        if (accept && !is_load)
        begin
            s1_valid_next = 1'b1;
        end
        s2_valid_next = s2_valid_reg && !s2_take;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept && !is_load)
        begin
            s1_mode_reg   <= item.mode;
            s1_row_reg    <= item.pick_row;
            s1_col_reg    <= item.pick_col;
            s1_letter_reg <= item.letter_a;
        end
        if (s1_adv)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_letter_reg <= s1_letter_reg;
        end
    end

    assign s2_stage.valid  = s2_valid_reg;
    assign s2_stage.mode   = s2_mode_reg;
    assign s2_stage.letter = s2_letter_reg;

    tsq_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (s2_stage),
        .sq1_data     (sq1_data),
        .sq2_data     (sq2_data),
        .sq3_data     (sq3_data),
        .take         (s2_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A load beat leaves stage one empty
    a_load_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_load |=> !s1_valid_reg)
        else $error("load beat entered the lookup pipeline");

    // A stalled stage-one item keeps its mode
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_mode_reg))
        else $error("stage one item lost while stalled");

    // Final beat with nothing queued empties the result channel
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last && !s2_valid_reg |=> !result_valid)
        else $error("result offered after final beat with empty pipeline");

endmodule

// ===== dv/trisquare_cipher_engine_tb.sv =====
module trisquare_cipher_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE         = tsq_pkg::SIDE_DEF;
    localparam int NCELL        = SIDE * SIDE;
    localparam int LETTER_W     = tsq_pkg::LETTER_W;
    localparam int LETTERS      = tsq_pkg::LETTERS;
    localparam int SEL_W        = tsq_pkg::SEL_W;
    localparam int CELL_W       = tsq_pkg::CELL_W;
    localparam int PICK_W       = tsq_pkg::PICK_W;
    localparam int RANDOM_ITEMS = 232;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;

    // One row of directed stimulus; typed rows carry their letters by hand
    typedef struct packed {
        tsq_pkg::item_t            it;
        logic                      typed;
        logic [1:0]                n;
        logic [2:0][LETTER_W-1:0]  want;
    } stim_row_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    tsq_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    tsq_pkg::result_t result;

    // Shadow copy of the three squares and their letter-to-cell maps
    logic [LETTER_W-1:0] key_square [3][NCELL];
    logic [LETTER_W-1:0] key_where  [3][LETTERS];

    tsq_pkg::result_t    pending_letters [$];
    int                  err_count   = 0;
    bit                  steady_send = 1'b0;
    bit                  have_tri    = 1'b0;
    logic [LETTER_W-1:0] last_tri [3];

    trisquare_cipher_engine #(
        .SIDE (SIDE)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Mostly short gaps, now and then a long one; none while steady
    function automatic int idle_cycles(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic tsq_pkg::item_t mk_item(input tsq_pkg::mode_t m, input int sel,
                                               input int cidx,
                                               input int a, input int b, input int c,
                                               input int pr, input int pc);
        tsq_pkg::item_t it;
        it.mode       = m;
        it.square_sel = SEL_W'(sel);
        it.cell_req   = CELL_W'(cidx);
        it.letter_a   = LETTER_W'(a);
        it.letter_b   = LETTER_W'(b);
        it.letter_c   = LETTER_W'(c);
        it.pick_row   = PICK_W'(pr);
        it.pick_col   = PICK_W'(pc);
        return it;
    endfunction

    function automatic stim_row_t plain_row(input tsq_pkg::item_t it);
        stim_row_t row;
        row       = '0;
        row.it    = it;
        row.typed = 1'b0;
        return row;
    endfunction

    // Pass beat: the echoed letter is known without the squares
    function automatic stim_row_t echo_row(input tsq_pkg::item_t it);
        stim_row_t row;
        row         = '0;
        row.it      = it;
        row.typed   = 1'b1;
        row.n       = 2'd1;
        row.want[0] = it.letter_a;
        return row;
    endfunction

    // Advance the shadow squares by one beat and work out its letters
    function automatic void cipher_letters(input tsq_pkg::item_t it, output int n,
                                           output tsq_pkg::result_t [2:0] outs);
        int prow, pcol, a, b, m, col1, row2;
        n    = 0;
        outs = '0;
        prow = (it.pick_row >= SIDE) ? SIDE - 1 : int'(it.pick_row);
        pcol = (it.pick_col >= SIDE) ? SIDE - 1 : int'(it.pick_col);
        case (it.mode)
            tsq_pkg::MODE_LOAD:
            begin
                // drop bad selects and cells past the square
                if (it.cell_req < NCELL && it.square_sel != tsq_pkg::SEL_NONE)
                begin
                    key_square[it.square_sel][it.cell_req] = it.letter_a;
                    key_where[it.square_sel][it.letter_a]  = it.cell_req;
                end
            end
            tsq_pkg::MODE_ENCRYPT:
            begin
                a = key_where[tsq_pkg::SEL_FIRST][it.letter_a];
                b = key_where[tsq_pkg::SEL_SECOND][it.letter_b];
                outs[0].letter_out = key_square[tsq_pkg::SEL_FIRST][prow * SIDE + a % SIDE];
                outs[1].letter_out =
                    key_square[tsq_pkg::SEL_THIRD][(a / SIDE) * SIDE + b % SIDE];
                outs[2].letter_out =
                    key_square[tsq_pkg::SEL_SECOND][(b / SIDE) * SIDE + pcol];
                outs[2].last       = 1'b1;
                n = 3;
            end
            tsq_pkg::MODE_DECRYPT:
            begin
                col1 = key_where[tsq_pkg::SEL_FIRST][it.letter_a] % SIDE;
                m    = key_where[tsq_pkg::SEL_THIRD][it.letter_b];
                row2 = key_where[tsq_pkg::SEL_SECOND][it.letter_c] / SIDE;
                outs[0].letter_out =
                    key_square[tsq_pkg::SEL_FIRST][(m / SIDE) * SIDE + col1];
                outs[1].letter_out =
                    key_square[tsq_pkg::SEL_SECOND][row2 * SIDE + m % SIDE];
                outs[1].last       = 1'b1;
                n = 2;
            end
            default:
            begin
                outs[0].letter_out = it.letter_a;
                outs[0].last       = 1'b1;
                n = 1;
            end
        endcase
    endfunction

    // Offer one beat, hold it until taken, then queue its letters
    task automatic send_item(input stim_row_t row);
        int                     gap;
        int                     n;
        tsq_pkg::result_t [2:0] outs;
        gap = idle_cycles(steady_send);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= row.it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        cipher_letters(row.it, n, outs);
        if (row.typed)
        begin
            n = row.n;
            for (int k = 0; k < 3; k++)
            begin
                outs[k].letter_out = row.want[k];
                outs[k].last       = (k == n - 1);
            end
        end
        if (row.it.mode == tsq_pkg::MODE_ENCRYPT)
        begin
            for (int k = 0; k < 3; k++)
                last_tri[k] = outs[k].letter_out;
            have_tri = 1'b1;
        end
        for (int k = 0; k < n; k++)
            pending_letters.push_back(outs[k]);
    endtask

    // Receiver: runs of ready with stalls between, a few runs very long
    initial
    begin : sink
        int on_len, off_len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                on_len = $urandom_range(60, 200);
            else
                on_len = $urandom_range(1, 8);
            result_ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            off_len = idle_cycles(1'b0);
            if (off_len > 0)
            begin
                result_ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    // Compare each letter beat with the oldest expectation
    always @(posedge clk)
    begin : check_letters
        tsq_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_letters.size() == 0)
                report_mismatch($sformatf("letter %0d with nothing pending",
                                          result.letter_out));
            else
            begin
                want = pending_letters.pop_front();
                if (result.letter_out !== want.letter_out)
                    report_mismatch($sformatf("letter_out %0d, want %0d",
                                              result.letter_out, want.letter_out));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              result.last, want.last));
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int             perm [NCELL];
        int             j, tmp, r, old12;
        stim_row_t      rows [$];
        tsq_pkg::item_t it;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Key every cell of all three squares with a fresh permutation
        for (int s = 0; s < 3; s++)
        begin
            for (int k = 0; k < NCELL; k++)
                perm[k] = k;
            for (int k = NCELL - 1; k > 0; k--)
            begin
                j       = $urandom_range(0, k);
                tmp     = perm[k];
                perm[k] = perm[j];
                perm[j] = tmp;
            end
            for (int c_idx = 0; c_idx < NCELL; c_idx++)
                send_item(plain_row(mk_item(tsq_pkg::MODE_LOAD, s, c_idx, perm[c_idx],
                                            $urandom_range(0, 31), $urandom_range(0, 31),
                                            $urandom_range(0, 7), $urandom_range(0, 7))));
        end
        old12 = key_square[tsq_pkg::SEL_FIRST][12];

        // Directed beats: extremes, ignored loads, saturated picks, overwrites
        rows.push_back(echo_row(mk_item(tsq_pkg::MODE_PASS, 0, 0, 0, 0, 0, 0, 0)));
        rows.push_back(echo_row(mk_item(tsq_pkg::MODE_PASS, 3, 31, 24, 31, 31, 7, 7)));
        rows.push_back(echo_row(mk_item(tsq_pkg::MODE_PASS, 2, 24, 13, 0, 31, 5, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_NONE,
                                         0, 7, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 7, 7, 0, 2, 2)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 0, 0, 7, 7, 7, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_FIRST,
                                         25, 9, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_SECOND,
                                         31, 9, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_THIRD,
                                         30, 9, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 9, 9, 0, 1, 3)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 0, 0, 9, 9, 9, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 0, 24, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 24, 0, 0, 4, 4)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 5, 6, 0, 5, 6)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 3, 31, 12, 19, 31, 7, 7)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 0, 0, 0, 24, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 3, 31, 24, 0, 24, 7, 7)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_FIRST,
                                         12, 3, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, 3, old12, 0, 3, 1)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_ENCRYPT, 0, 0, old12, 3, 0, 2, 4)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 0, 0, old12, 3, 3, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_LOAD, tsq_pkg::SEL_THIRD,
                                         0, 24, 0, 0, 0, 0)));
        rows.push_back(plain_row(mk_item(tsq_pkg::MODE_DECRYPT, 0, 0, 5, 24, 5, 0, 0)));
        foreach (rows[k])
            send_item(rows[k]);

        // Random beats; unused fields take their full width
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                steady_send = !steady_send;
            r  = $urandom_range(0, 99);
            it = mk_item(tsq_pkg::MODE_PASS, $urandom_range(0, 3), $urandom_range(0, 31),
                         $urandom_range(0, 24), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 7),
                         $urandom_range(0, 7));
            if (r < 12)
            begin
                it.mode = tsq_pkg::MODE_LOAD;
                // mostly good loads; the rest keep a possibly bad select or cell
                if ($urandom_range(0, 3) != 0)
                begin
                    it.square_sel = SEL_W'($urandom_range(0, 2));
                    it.cell_req   = CELL_W'($urandom_range(0, NCELL - 1));
                end
            end
            else if (r < 47)
            begin
                it.mode     = tsq_pkg::MODE_ENCRYPT;
                it.letter_b = LETTER_W'($urandom_range(0, 24));
            end
            else if (r < 80)
            begin
                it.mode     = tsq_pkg::MODE_DECRYPT;
                it.letter_b = LETTER_W'($urandom_range(0, 24));
                it.letter_c = LETTER_W'($urandom_range(0, 24));
                // round trip: feed back the latest trigraph now and then
                if (have_tri && $urandom_range(0, 2) == 0)
                begin
                    it.letter_a = last_tri[0];
                    it.letter_b = last_tri[1];
                    it.letter_c = last_tri[2];
                end
            end
            send_item(plain_row(it));
        end
        item_valid <= 1'b0;

        while (pending_letters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
